// ===== rtl/les_pkg.sv =====
`timescale 1ns / 1ps

package les_pkg;

   // fixed field widths of the screen-space coordinates
   localparam int ORG_BITS = 16;
   localparam int OUT_BITS = 26;

endpackage

// ===== rtl/les_if.sv =====
`timescale 1ns / 1ps

interface les_req_if #(
   parameter int SIZE_BITS = 12
);
   logic                              valid;
   logic                              ready;
   logic [SIZE_BITS-1:0]              run;
   logic [SIZE_BITS-1:0]              rise;
   logic [SIZE_BITS-1:0]              start_offset;
   logic [SIZE_BITS-1:0]              seg_length;
   logic signed [les_pkg::ORG_BITS-1:0] origin_x;
   logic signed [les_pkg::ORG_BITS-1:0] origin_y;
   logic                              swap_axes;
   logic                              flip_x;
   logic                              flip_y;

   modport source (output valid, run, rise, start_offset, seg_length, origin_x, origin_y,
                   swap_axes, flip_x, flip_y, input ready);
   modport sink (input valid, run, rise, start_offset, seg_length, origin_x, origin_y,
                 swap_axes, flip_x, flip_y, output ready);
endinterface

interface les_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [les_pkg::OUT_BITS-1:0] start_x;
   logic signed [les_pkg::OUT_BITS-1:0] start_y;
   logic signed [les_pkg::OUT_BITS-1:0] end_x;
   logic signed [les_pkg::OUT_BITS-1:0] end_y;
   logic                              div_error;

   modport source (output valid, start_x, start_y, end_x, end_y, div_error, input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, div_error, output ready);
endinterface

// ===== rtl/les_div_pipe.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per register stage, lanes share a divisor
module les_div_pipe #(
   parameter int NUM_W = 12,
   parameter int DEN_W = 12,
   parameter int LANES = 1,
   parameter int PAY_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num [LANES],
   input  logic [DEN_W-1:0] in_den,
   input  logic [PAY_W-1:0] in_pay,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo [LANES],
   output logic [DEN_W-1:0] out_rem [LANES],
   output logic [PAY_W-1:0] out_pay
);

   logic             vld_ff [NUM_W];
   logic [NUM_W-1:0] nq_ff  [NUM_W][LANES];
   logic [DEN_W-1:0] rem_ff [NUM_W][LANES];
   logic [DEN_W-1:0] den_ff [NUM_W];
   logic [PAY_W-1:0] pay_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic             src_vld;
      logic [NUM_W-1:0] src_nq  [LANES];
      logic [DEN_W-1:0] src_rem [LANES];
      logic [DEN_W-1:0] src_den;
      logic [PAY_W-1:0] src_pay;
      logic [NUM_W-1:0] nq_in   [LANES];
      logic [DEN_W-1:0] rem_in  [LANES];

      if (k == 0) begin : g_first
         always_comb begin
            src_vld = in_valid;
            src_den = in_den;
            src_pay = in_pay;
            for (int l = 0; l < LANES; l++) begin
               src_nq[l]  = in_num[l];
               src_rem[l] = '0;
            end
         end
      end else begin : g_next
         always_comb begin
            src_vld = vld_ff[k-1];
            src_den = den_ff[k-1];
            src_pay = pay_ff[k-1];
            for (int l = 0; l < LANES; l++) begin
               src_nq[l]  = nq_ff[k-1][l];
               src_rem[l] = rem_ff[k-1][l];
            end
         end
      end

      always_comb begin
         logic [DEN_W:0] trial;
         logic [DEN_W:0] diff;
         logic           ge;
         for (int l = 0; l < LANES; l++) begin
            trial = {src_rem[l], src_nq[l][NUM_W-1]};
            diff  = trial - {1'b0, src_den};
            ge    = trial >= {1'b0, src_den};
            rem_in[l] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            nq_in[l]  = {src_nq[l][NUM_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= src_vld;
         end
         if (advance) begin
            den_ff[k] <= src_den;
            pay_ff[k] <= src_pay;
            for (int l = 0; l < LANES; l++) begin
               nq_ff[k][l]  <= nq_in[l];
               rem_ff[k][l] <= rem_in[l];
            end
         end
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign out_pay   = pay_ff[NUM_W-1];
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_quo[l] = nq_ff[NUM_W-1][l];
         out_rem[l] = rem_ff[NUM_W-1][l];
      end
   end

endmodule

// ===== rtl/line_endpoint_setup_core.sv =====
`timescale 1ns / 1ps

// channel   dir  interface   carries
// req_chan  in   les_req_if  run, rise, start_offset, seg_length, origin, octant flags
// rsp_chan  out  les_rsp_if  start_x, start_y, end_x, end_y, div_error
//
// one transaction per cycle unless rsp_chan stalls; stages: input register, remainder
// divider (SIZE_BITS stages), setup register, interpolation divider (2*SIZE_BITS +
// FRAC_BITS + 1 stages), local and output registers; one quotient bit per divider stage
// reset clears the valid bits of every stage
// a stall at rsp_chan freezes the whole pipeline; req_chan.ready drops only then
module line_endpoint_setup_core #(
   parameter int FRAC_BITS = 8,
   parameter int SIZE_BITS = 12
) (
   input  logic     clock,
   input  logic     reset,
   les_req_if.sink  req_chan,
   les_rsp_if.source rsp_chan
);

   localparam int N   = SIZE_BITS;
   localparam int F   = FRAC_BITS;
   localparam int OB  = les_pkg::ORG_BITS;
   localparam int OW  = les_pkg::OUT_BITS;
   localparam int QW  = 2 * N + F + 1;
   localparam int LW  = QW + 2;
   localparam int SW  = LW + 1;

   localparam logic signed [LW-1:0] ONE_L  = LW'(1) << F;
   localparam logic signed [LW-1:0] HALF_L = LW'(1) << (F - 1);
   localparam logic signed [SW-1:0] SAT_HI = SW'((2 ** (OW - 1)) - 1);
   localparam logic signed [SW-1:0] SAT_LO = -(SW'(2 ** (OW - 1)));

   typedef struct packed {
      logic [N-1:0]         run;
      logic [N-1:0]         rise;
      logic [N-1:0]         start_offset;
      logic [N-1:0]         seg_length;
      logic signed [OB-1:0] origin_x;
      logic signed [OB-1:0] origin_y;
      logic                 swap_axes;
      logic                 flip_x;
      logic                 flip_y;
   } req_type;

   typedef struct packed {
      logic [N-1:0]         seg_length;
      logic signed [OB-1:0] origin_x;
      logic signed [OB-1:0] origin_y;
      logic                 swap_axes;
      logic                 flip_x;
      logic                 flip_y;
      logic                 straight;
      logic                 err;
   } setup_type;

   typedef struct packed {
      logic signed [LW-1:0] a1;
      logic signed [LW-1:0] b1;
      logic signed [LW-1:0] a2;
      logic signed [LW-1:0] b2;
      logic signed [OB-1:0] origin_x;
      logic signed [OB-1:0] origin_y;
      logic                 flip_x;
      logic                 flip_y;
      logic                 err;
   } local_type;

   logic advance;
   assign advance        = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   // input register
   req_type req_ff;
   logic    req_vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (advance) begin
         req_vld_ff <= req_chan.valid;
      end
      if (advance) begin
         req_ff.run          <= req_chan.run;
         req_ff.rise         <= req_chan.rise;
         req_ff.start_offset <= req_chan.start_offset;
         req_ff.seg_length   <= req_chan.seg_length;
         req_ff.origin_x     <= req_chan.origin_x;
         req_ff.origin_y     <= req_chan.origin_y;
         req_ff.swap_axes    <= req_chan.swap_axes;
         req_ff.flip_x       <= req_chan.flip_x;
         req_ff.flip_y       <= req_chan.flip_y;
      end
   end

   // rise % run
   logic [N-1:0]             mod_num [1];
   logic [N-1:0]             mod_rem [1];
   logic                     mod_vld;
   logic [$bits(req_type)-1:0] mod_pay;
   assign mod_num[0] = req_ff.rise;

   les_div_pipe #(
      .NUM_W(N), .DEN_W(N), .LANES(1), .PAY_W($bits(req_type))
   ) u_mod (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(req_vld_ff), .in_num(mod_num), .in_den(req_ff.run), .in_pay(req_ff),
      .out_valid(mod_vld), .out_quo(), .out_rem(mod_rem), .out_pay(mod_pay)
   );

   // numerators of the truncated offset and the two interpolations
   req_type   mq;
   setup_type setup_in;
   logic [QW-1:0] nxo_in, n1_in, n2_in;
   always_comb begin
      logic         adj;
      logic         h;
      logic [N+1:0] t1;
      logic [N+1:0] t2;
      logic [2*N-1:0] px;
      logic [2*N+1:0] p1;
      logic [2*N+1:0] p2;
      mq  = req_type'(mod_pay);
      adj = mod_rem[0] != '0;
      h   = !adj;
      t1  = {1'b0, mq.start_offset, 1'b0} + (N+2)'(h);
      t2  = {1'b0, mq.start_offset, 1'b0} + {1'b0, mq.seg_length, 1'b0}
            - (N+2)'(2) + (N+2)'(h);
      px  = (2*N)'(mq.run) * (2*N)'(mq.start_offset);
      p1  = (2*N+2)'(mq.run) * (2*N+2)'(t1);
      p2  = (2*N+2)'(mq.run) * (2*N+2)'(t2);
      nxo_in = {{(F+1){1'b0}}, px};
      n1_in  = {p1, {(F-1){1'b0}}};
      n2_in  = {p2, {(F-1){1'b0}}};
      setup_in.seg_length = mq.seg_length;
      setup_in.origin_x   = mq.origin_x;
      setup_in.origin_y   = mq.origin_y;
      setup_in.swap_axes  = mq.swap_axes;
      setup_in.flip_x     = mq.flip_x;
      setup_in.flip_y     = mq.flip_y;
      setup_in.straight   = (mq.run == N'(1)) && (mq.seg_length <= mq.rise);
      if (mq.run == '0 || mq.rise == '0) begin
         setup_in.err = 1'b1;
      end else if (setup_in.straight) begin
         setup_in.err = 1'b0;
      end else begin
         setup_in.err = (mq.seg_length == '0) || (adj && mq.seg_length == mq.start_offset);
      end
   end

   setup_type     setup_ff;
   logic [QW-1:0] num_ff [3];
   logic [N-1:0]  den_ff;
   logic          setup_vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         setup_vld_ff <= 1'b0;
      end else if (advance) begin
         setup_vld_ff <= mod_vld;
      end
      if (advance) begin
         setup_ff  <= setup_in;
         num_ff[0] <= nxo_in;
         num_ff[1] <= n1_in;
         num_ff[2] <= n2_in;
         den_ff    <= mq.rise;
      end
   end

   logic [QW-1:0]                quo [3];
   logic                         div_vld;
   logic [$bits(setup_type)-1:0] div_pay;

   les_div_pipe #(
      .NUM_W(QW), .DEN_W(N), .LANES(3), .PAY_W($bits(setup_type))
   ) u_interp (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(setup_vld_ff), .in_num(num_ff), .in_den(den_ff), .in_pay(setup_ff),
      .out_valid(div_vld), .out_quo(quo), .out_rem(), .out_pay(div_pay)
   );

   // local frame, then axis swap
   setup_type dq;
   local_type loc_in;
   always_comb begin
      logic [LW-1:0]        xo_ext;
      logic signed [LW-1:0] base;
      logic signed [LW-1:0] lx1, lx2, ly1, ly2;
      dq     = setup_type'(div_pay);
      xo_ext = {{(LW-QW){1'b0}}, quo[0]};
      base   = HALF_L - $signed(xo_ext << F);
      ly1    = HALF_L;
      ly2    = $signed({{(LW-N){1'b0}}, dq.seg_length} << F) - HALF_L;
      if (dq.straight) begin
         lx1 = ONE_L;
         lx2 = ONE_L;
      end else begin
         lx1 = base + $signed({{(LW-QW){1'b0}}, quo[1]});
         lx2 = base + $signed({{(LW-QW){1'b0}}, quo[2]});
      end
      loc_in.a1       = dq.swap_axes ? ly1 : lx1;
      loc_in.b1       = dq.swap_axes ? lx1 : ly1;
      loc_in.a2       = dq.swap_axes ? ly2 : lx2;
      loc_in.b2       = dq.swap_axes ? lx2 : ly2;
      loc_in.origin_x = dq.origin_x;
      loc_in.origin_y = dq.origin_y;
      loc_in.flip_x   = dq.flip_x;
      loc_in.flip_y   = dq.flip_y;
      loc_in.err      = dq.err;
   end

   local_type loc_ff;
   logic      loc_vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         loc_vld_ff <= 1'b0;
      end else if (advance) begin
         loc_vld_ff <= div_vld;
      end
      if (advance) begin
         loc_ff <= loc_in;
      end
   end

   // placement about the origin and saturation
   function automatic logic signed [OW-1:0] place_sat(
      input logic signed [OB-1:0] org,
      input logic                 flip,
      input logic signed [LW-1:0] lcl
   );
      logic signed [SW-1:0] org_ext;
      logic signed [SW-1:0] lcl_ext;
      logic signed [SW-1:0] scaled;
      logic signed [SW-1:0] v;
      org_ext = {{(SW-OB){org[OB-1]}}, org};
      lcl_ext = {lcl[LW-1], lcl};
      scaled  = (flip ? org_ext + SW'(1) : org_ext) <<< F;
      v       = flip ? scaled - lcl_ext : scaled + lcl_ext;
      if (v > SAT_HI) begin
         place_sat = SAT_HI[OW-1:0];
      end else if (v < SAT_LO) begin
         place_sat = SAT_LO[OW-1:0];
      end else begin
         place_sat = v[OW-1:0];
      end
   endfunction

   logic                 out_vld_ff;
   logic signed [OW-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic                 err_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= loc_vld_ff;
      end
      if (advance) begin
         err_ff <= loc_ff.err;
         if (loc_ff.err) begin
            sx_ff <= '0;
            sy_ff <= '0;
            ex_ff <= '0;
            ey_ff <= '0;
         end else begin
            sx_ff <= place_sat(loc_ff.origin_x, loc_ff.flip_x, loc_ff.a1);
            sy_ff <= place_sat(loc_ff.origin_y, loc_ff.flip_y, loc_ff.b1);
            ex_ff <= place_sat(loc_ff.origin_x, loc_ff.flip_x, loc_ff.a2);
            ey_ff <= place_sat(loc_ff.origin_y, loc_ff.flip_y, loc_ff.b2);
         end
      end
   end

   assign rsp_chan.valid     = out_vld_ff;
   assign rsp_chan.start_x   = sx_ff;
   assign rsp_chan.start_y   = sy_ff;
   assign rsp_chan.end_x     = ex_ff;
   assign rsp_chan.end_y     = ey_ff;
   assign rsp_chan.div_error = err_ff;

endmodule

// ===== rtl/les_checker.sv =====
`timescale 1ns / 1ps

module les_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [les_pkg::OUT_BITS-1:0] rsp_start_x,
   input logic signed [les_pkg::OUT_BITS-1:0] rsp_start_y,
   input logic signed [les_pkg::OUT_BITS-1:0] rsp_end_x,
   input logic signed [les_pkg::OUT_BITS-1:0] rsp_end_y,
   input logic                              rsp_div_error
);

   // an empty output stage always lets the pipeline move
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req not ready while output empty");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_error) |->
         (rsp_start_x == '0 && rsp_start_y == '0 && rsp_end_x == '0 && rsp_end_y == '0))
      else $error("error transaction with nonzero endpoints");

   a_no_valid_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_hold_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_start_x) && $stable(rsp_start_y) && $stable(rsp_end_x)
          && $stable(rsp_end_y) && $stable(rsp_div_error)))
      else $error("stalled rsp transaction changed");

endmodule

bind line_endpoint_setup_core les_checker u_les_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_start_x(rsp_chan.start_x),
   .rsp_start_y(rsp_chan.start_y),
   .rsp_end_x(rsp_chan.end_x),
   .rsp_end_y(rsp_chan.end_y),
   .rsp_div_error(rsp_chan.div_error)
);
